/* sv/cold_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cold_pkg
// Shared constants, payload types, rounding and saturation helpers for the camera
// placement pipeline.
// ----------------------------------------------------------------------------
package cold_pkg;

  // Fraction bits of a unit vector component.
  localparam int UNIT_BITS = 28;

  typedef enum logic [1:0] {
    OUT_ON_LINE  = 2'd0,
    OUT_FAR      = 2'd1,
    OUT_ZERO_DIR = 2'd2
  } outcome_t;

  // Input word as it travels alongside the first unit vector.
  typedef struct packed {
    logic [2:0][31:0] p;
    logic [2:0][31:0] f;
    logic [2:0][32:0] fp;
    logic [30:0]      d;
  } geo_t;

  // Foot point, offset and flags on their way through the distance root.
  typedef struct packed {
    logic [2:0][30:0] e;
    logic             nz;
    logic             far;
    logic [2:0][35:0] pf;
    logic [2:0][35:0] w;
    logic [2:0][31:0] f;
    logic [30:0]      d;
  } mid_t;

  // What the final stages need once the second unit vector is done.
  typedef struct packed {
    logic [2:0][30:0] e;
    logic             nz;
    logic             far;
    logic [2:0][35:0] pf;
    logic [2:0][31:0] f;
    logic [30:0]      d;
    logic [31:0]      q;
  } tail_t;

  // Divide by 2^UNIT_BITS, rounding to nearest with halves away from zero.
  function automatic logic signed [39:0] unit_scale(input logic signed [67:0] v);
    logic [67:0] m;
    logic [67:0] s;
    m = v[67] ? (~v + 68'd1) : v;
    s = (m + (68'd1 << (UNIT_BITS - 1))) >> UNIT_BITS;
    unit_scale = v[67] ? -$signed(s[39:0]) : $signed(s[39:0]);
  endfunction

  // Saturate to the signed 32 bit range.
  function automatic logic [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) begin
      sat32 = 32'h7FFF_FFFF;
    end else if (v < -40'sd2147483648) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

/* sv/cold_isqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cold_isqrt
// Pipelined square root of a 62 bit value, rounded to nearest. One result
// bit is settled per stage, followed by a rounding stage.
// ----------------------------------------------------------------------------
module cold_isqrt #(
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [61:0]   in_x,
  input  logic [PW-1:0] in_pl,
  output logic          out_valid,
  output logic [31:0]   out_root,
  output logic [PW-1:0] out_pl
);

  localparam int NSTEP = 32;

  logic [63:0]   n_r  [NSTEP];
  logic [63:0]   r_r  [NSTEP];
  logic          v_r  [NSTEP];
  logic [PW-1:0] pl_r [NSTEP];

  logic          v_out_r;
  logic [31:0]   root_r;
  logic [PW-1:0] pl_out_r;
  logic [31:0]   root_nxt;

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    logic [63:0]   n_in;
    logic [63:0]   r_in;
    logic [63:0]   bitv;
    logic [63:0]   trial;
    logic          v_in;
    logic [PW-1:0] pl_in;

    if (k == 0) begin : g_first
      assign n_in  = {2'b00, in_x};
      assign r_in  = '0;
      assign v_in  = in_valid;
      assign pl_in = in_pl;
    end else begin : g_next
      assign n_in  = n_r[k-1];
      assign r_in  = r_r[k-1];
      assign v_in  = v_r[k-1];
      assign pl_in = pl_r[k-1];
    end

    assign bitv  = 64'd1 << (62 - 2 * k);
    assign trial = r_in + bitv;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
      if (en) begin
        if (n_in >= trial) begin
          n_r[k] <= n_in - trial;
          r_r[k] <= (r_in >> 1) + bitv;
        end else begin
          n_r[k] <= n_in;
          r_r[k] <= r_in >> 1;
        end
        pl_r[k] <= pl_in;
      end
    end
  end

  // The remainder already equals x - r*r, so rounding needs no multiply.
  assign root_nxt = r_r[NSTEP-1][31:0] + 32'(n_r[NSTEP-1] > r_r[NSTEP-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_out_r <= 1'b0;
    end else if (en) begin
      v_out_r <= v_r[NSTEP-1];
    end
    if (en) begin
      root_r   <= root_nxt;
      pl_out_r <= pl_r[NSTEP-1];
    end
  end

  assign out_valid = v_out_r;
  assign out_root  = root_r;
  assign out_pl    = pl_out_r;

endmodule

/* sv/cold_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cold_div
// Pipelined restoring divider for three numerators over one shared
// divisor. One quotient bit per stage; quotients must fit in 30 bits.
// ----------------------------------------------------------------------------
module cold_div #(
  parameter int PW = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [2:0][58:0]      in_num,
  input  logic [31:0]           in_den,
  input  logic [PW-1:0]         in_pl,
  output logic                  out_valid,
  output logic [2:0][29:0]      out_quot,
  output logic [PW-1:0]         out_pl
);

  localparam int NQ = 30;

  logic [2:0][58:0] rem_r [NQ];
  logic [2:0][29:0] quo_r [NQ];
  logic [31:0]      den_r [NQ];
  logic             v_r   [NQ];
  logic [PW-1:0]    pl_r  [NQ];

  for (genvar k = 0; k < NQ; k++) begin : g_step
    logic [2:0][58:0] rem_in;
    logic [2:0][29:0] quo_in;
    logic [31:0]      den_in;
    logic             v_in;
    logic [PW-1:0]    pl_in;
    logic [60:0]      sh;

    if (k == 0) begin : g_first
      assign rem_in = in_num;
      assign quo_in = '0;
      assign den_in = in_den;
      assign v_in   = in_valid;
      assign pl_in  = in_pl;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign quo_in = quo_r[k-1];
      assign den_in = den_r[k-1];
      assign v_in   = v_r[k-1];
      assign pl_in  = pl_r[k-1];
    end

    assign sh = 61'(den_in) << (NQ - 1 - k);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
      if (en) begin
        for (int j = 0; j < 3; j++) begin
          if ({2'b00, rem_in[j]} >= sh) begin
            rem_r[k][j] <= rem_in[j] - sh[58:0];
            quo_r[k][j] <= {quo_in[j][28:0], 1'b1};
          end else begin
            rem_r[k][j] <= rem_in[j];
            quo_r[k][j] <= {quo_in[j][28:0], 1'b0};
          end
        end
        den_r[k] <= den_in;
        pl_r[k]  <= pl_in;
      end
    end
  end

  assign out_valid = v_r[NQ-1];
  assign out_quot  = quo_r[NQ-1];
  assign out_pl    = pl_r[NQ-1];

endmodule

/* sv/cold_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cold_unit
// Pipelined unit vector: scales the magnitudes by a common power of two,
// takes the rounded length and divides each component by it, giving
// signed components with 28 fraction bits.
// ----------------------------------------------------------------------------
module cold_unit #(
  parameter int PW = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [2:0][35:0]        in_c,
  input  logic [PW-1:0]           in_pl,
  output logic                    out_valid,
  output logic [2:0][30:0]        out_u,
  output logic                    out_nz,
  output logic [PW-1:0]           out_pl
);

  localparam int SPW = PW + 3 + 1 + 90;
  localparam int DPW = PW + 3 + 1;

  // Stage A: magnitudes and signs.
  logic             v_a_r;
  logic [2:0][35:0] mag_a_r;
  logic [2:0]       neg_a_r;
  logic [PW-1:0]    pl_a_r;
  logic [2:0][35:0] mag_a_nxt;

  // Stage B: largest magnitude.
  logic             v_b_r;
  logic [2:0][35:0] mag_b_r;
  logic [2:0]       neg_b_r;
  logic [35:0]      big_b_r;
  logic [PW-1:0]    pl_b_r;
  logic [35:0]      big_b_nxt;

  // Stage C: common scaling.
  logic             v_c_r;
  logic [2:0][29:0] m_c_r;
  logic [2:0]       neg_c_r;
  logic             nz_c_r;
  logic [PW-1:0]    pl_c_r;
  logic [2:0][29:0] m_c_nxt;
  logic [5:0]       pos;

  // Stage D: squares.
  logic             v_d_r;
  logic [2:0][59:0] sq_d_r;
  logic [2:0][29:0] m_d_r;
  logic [2:0]       neg_d_r;
  logic             nz_d_r;
  logic [PW-1:0]    pl_d_r;

  // Stage E: sum of squares.
  logic             v_e_r;
  logic [61:0]      n2_e_r;
  logic [2:0][29:0] m_e_r;
  logic [2:0]       neg_e_r;
  logic             nz_e_r;
  logic [PW-1:0]    pl_e_r;

  logic             sq_valid;
  logic [31:0]      sq_root;
  logic [SPW-1:0]   sq_pl;
  logic [2:0][29:0] sq_m;
  logic [2:0]       sq_neg;
  logic             sq_nz;
  logic [PW-1:0]    sq_plu;
  logic [2:0][58:0] num;

  logic             dv_valid;
  logic [2:0][29:0] dv_quot;
  logic [DPW-1:0]   dv_pl;
  logic [2:0]       dv_neg;
  logic             dv_nz;
  logic [PW-1:0]    dv_plu;

  logic             v_f_r;
  logic [2:0][30:0] u_f_r;
  logic             nz_f_r;
  logic [PW-1:0]    pl_f_r;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      mag_a_nxt[j] = in_c[j][35] ? (~in_c[j] + 36'd1) : in_c[j];
    end
  end

  always_comb begin
    big_b_nxt = mag_a_r[0];
    if (mag_a_r[1] > big_b_nxt) begin
      big_b_nxt = mag_a_r[1];
    end
    if (mag_a_r[2] > big_b_nxt) begin
      big_b_nxt = mag_a_r[2];
    end
  end

  // Bring the largest magnitude into [2^29, 2^30); right shifts truncate.
  always_comb begin
    pos = '0;
    for (int i = 0; i < 36; i++) begin
      if (big_b_r[i]) begin
        pos = 6'(i);
      end
    end
    for (int j = 0; j < 3; j++) begin
      if (pos > 6'd29) begin
        m_c_nxt[j] = 30'(mag_b_r[j] >> (pos - 6'd29));
      end else begin
        m_c_nxt[j] = 30'({30'b0, mag_b_r[j]} << (6'd29 - pos));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      v_d_r <= 1'b0;
      v_e_r <= 1'b0;
      v_f_r <= 1'b0;
    end else if (en) begin
      v_a_r <= in_valid;
      v_b_r <= v_a_r;
      v_c_r <= v_b_r;
      v_d_r <= v_c_r;
      v_e_r <= v_d_r;
      v_f_r <= dv_valid;
    end
    if (en) begin
      mag_a_r <= mag_a_nxt;
      for (int j = 0; j < 3; j++) begin
        neg_a_r[j] <= in_c[j][35];
      end
      pl_a_r  <= in_pl;

      mag_b_r <= mag_a_r;
      neg_b_r <= neg_a_r;
      big_b_r <= big_b_nxt;
      pl_b_r  <= pl_a_r;

      m_c_r   <= m_c_nxt;
      neg_c_r <= neg_b_r;
      nz_c_r  <= (big_b_r != '0);
      pl_c_r  <= pl_b_r;

      for (int j = 0; j < 3; j++) begin
        sq_d_r[j] <= m_c_r[j] * m_c_r[j];
      end
      m_d_r   <= m_c_r;
      neg_d_r <= neg_c_r;
      nz_d_r  <= nz_c_r;
      pl_d_r  <= pl_c_r;

      n2_e_r  <= 62'(sq_d_r[0]) + 62'(sq_d_r[1]) + 62'(sq_d_r[2]);
      m_e_r   <= m_d_r;
      neg_e_r <= neg_d_r;
      nz_e_r  <= nz_d_r;
      pl_e_r  <= pl_d_r;

      for (int j = 0; j < 3; j++) begin
        u_f_r[j] <= dv_neg[j] ? -$signed({1'b0, dv_quot[j]})
                              : $signed({1'b0, dv_quot[j]});
      end
      nz_f_r <= dv_nz;
      pl_f_r <= dv_plu;
    end
  end

  cold_isqrt #(
    .PW (SPW)
  ) u_len (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v_e_r),
    .in_x      (n2_e_r),
    .in_pl     ({pl_e_r, neg_e_r, nz_e_r, m_e_r}),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_pl    (sq_pl)
  );

  assign {sq_plu, sq_neg, sq_nz, sq_m} = sq_pl;

  // Numerators carry half the length so that the quotient rounds to nearest.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      num[j] = 59'({sq_m[j], 28'b0}) + 59'(sq_root >> 1);
    end
  end

  cold_div #(
    .PW (DPW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_valid),
    .in_num    (num),
    .in_den    (sq_root),
    .in_pl     ({sq_plu, sq_neg, sq_nz}),
    .out_valid (dv_valid),
    .out_quot  (dv_quot),
    .out_pl    (dv_pl)
  );

  assign {dv_plu, dv_neg, dv_nz} = dv_pl;

  assign out_valid = v_f_r;
  assign out_u     = u_f_r;
  assign out_nz    = nz_f_r;
  assign out_pl    = pl_f_r;

endmodule

/* sv/camera_on_line_at_distance.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_on_line_at_distance
// Places a camera on a line at a given distance from a focus point, or at
// that distance from the focus away from the line when the line is too far.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle unless stalled and returns one
// result word for each, in order. The path runs twice through
// the unit vector pipeline (length root and three dividers, one bit per
// stage) and once through the root of the remaining distance. A stall on
// the result side holds the whole pipeline, and the input stalls with it.
// ----------------------------------------------------------------------------
module camera_on_line_at_distance (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_line_px,
  input  logic [31:0] in_line_py,
  input  logic [31:0] in_line_pz,
  input  logic [31:0] in_dir_x,
  input  logic [31:0] in_dir_y,
  input  logic [31:0] in_dir_z,
  input  logic [31:0] in_focus_x,
  input  logic [31:0] in_focus_y,
  input  logic [31:0] in_focus_z,
  input  logic [30:0] in_cam_distance,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_cam_x,
  output logic [31:0] out_cam_y,
  output logic [31:0] out_cam_z,
  output logic [1:0]  out_outcome
);

  logic en;

  // Capture stage.
  logic                  v0_r;
  cold_pkg::geo_t        g0_r;
  logic [2:0][31:0]      dv0_r;
  cold_pkg::geo_t        g0_nxt;
  logic [2:0][35:0]      c1;

  // First unit vector.
  logic                  v1;
  logic [2:0][30:0]      e1;
  logic                  nz1;
  logic [$bits(cold_pkg::geo_t)-1:0] g1_raw;
  cold_pkg::geo_t        g1;

  logic                  v2_r, v3_r, v4_r, v5_r, v6_r;
  logic [2:0][63:0]      pr2_r;
  logic signed [65:0]    acc3_r;
  logic signed [35:0]    t4_r;
  logic [2:0][66:0]      te5_r;
  logic [2:0][35:0]      pf6_r;
  logic [2:0][30:0]      e2_r, e3_r, e4_r, e5_r, e6_r;
  logic                  nz2_r, nz3_r, nz4_r, nz5_r, nz6_r;
  cold_pkg::geo_t        g2_r, g3_r, g4_r, g5_r, g6_r;

  logic                  v7_r, v8_r, v9_r, v10_r;
  cold_pkg::mid_t        m7_r, m8_r, m9_r, m10_r;
  cold_pkg::mid_t        m7_nxt;
  cold_pkg::mid_t        m9_nxt;
  cold_pkg::mid_t        m10_nxt;
  logic [2:0][35:0]      mag8_r;
  logic [2:0][61:0]      sq9_r;
  logic [61:0]           d2_9_r;
  logic [61:0]           diff10_r;
  logic [63:0]           w2;

  logic                  v_sq;
  logic [31:0]           q_sq;
  logic [$bits(cold_pkg::mid_t)-1:0] m_sq_raw;
  cold_pkg::mid_t        m_sq;
  cold_pkg::tail_t       tl_in;

  logic                  v_u2;
  logic [2:0][30:0]      u2;
  logic                  nz_u2;
  logic [$bits(cold_pkg::tail_t)-1:0] tl_raw;
  cold_pkg::tail_t       tl;

  logic                  v11_r;
  logic [2:0][63:0]      qe11_r;
  logic [2:0][62:0]      ud11_r;
  cold_pkg::tail_t       tl11_r;
  cold_pkg::tail_t       tl11_nxt;

  logic                  v12_r;
  logic [2:0][39:0]      cam12_r;
  cold_pkg::outcome_t    oc12_r;
  logic [2:0][39:0]      cam12_nxt;
  cold_pkg::outcome_t    oc12_nxt;

  logic                  out_valid_r;
  logic [2:0][31:0]      cam_out_r;
  cold_pkg::outcome_t    oc_out_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_comb begin
    g0_nxt.p  = {in_line_pz, in_line_py, in_line_px};
    g0_nxt.f  = {in_focus_z, in_focus_y, in_focus_x};
    g0_nxt.d  = in_cam_distance;
    g0_nxt.fp[0] = 33'($signed(in_focus_x)) - 33'($signed(in_line_px));
    g0_nxt.fp[1] = 33'($signed(in_focus_y)) - 33'($signed(in_line_py));
    g0_nxt.fp[2] = 33'($signed(in_focus_z)) - 33'($signed(in_line_pz));
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      c1[j] = 36'($signed(dv0_r[j]));
    end
  end

  cold_unit #(
    .PW ($bits(cold_pkg::geo_t))
  ) u_dir_unit (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v0_r),
    .in_c      (c1),
    .in_pl     (g0_r),
    .out_valid (v1),
    .out_u     (e1),
    .out_nz    (nz1),
    .out_pl    (g1_raw)
  );

  assign g1 = cold_pkg::geo_t'(g1_raw);

  // Offset of the focus from the foot point, with a flag for the far case.
  always_comb begin
    m7_nxt.e   = e6_r;
    m7_nxt.nz  = nz6_r;
    m7_nxt.far = 1'b0;
    m7_nxt.pf  = pf6_r;
    m7_nxt.f   = g6_r.f;
    m7_nxt.d   = g6_r.d;
    for (int j = 0; j < 3; j++) begin
      m7_nxt.w[j] = 36'($signed(g6_r.f[j])) - $signed(pf6_r[j]);
    end
  end

  // An offset component of 2^31 or more puts the line beyond any distance.
  always_comb begin
    m9_nxt     = m8_r;
    m9_nxt.far = (mag8_r[0][35:31] != '0) || (mag8_r[1][35:31] != '0)
              || (mag8_r[2][35:31] != '0);
  end

  always_comb begin
    m10_nxt     = m9_r;
    m10_nxt.far = m9_r.far || (w2 > 64'(d2_9_r));
  end

  assign w2 = 64'(sq9_r[0]) + 64'(sq9_r[1]) + 64'(sq9_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      v6_r  <= 1'b0;
      v7_r  <= 1'b0;
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
    end else if (en) begin
      v0_r  <= in_valid;
      v2_r  <= v1;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      v5_r  <= v4_r;
      v6_r  <= v5_r;
      v7_r  <= v6_r;
      v8_r  <= v7_r;
      v9_r  <= v8_r;
      v10_r <= v9_r;
    end
    if (en) begin
      g0_r  <= g0_nxt;
      dv0_r <= {in_dir_z, in_dir_y, in_dir_x};

      for (int j = 0; j < 3; j++) begin
        pr2_r[j] <= 64'($signed(g1.fp[j]) * $signed(e1[j]));
      end
      e2_r  <= e1;
      nz2_r <= nz1;
      g2_r  <= g1;

      acc3_r <= 66'($signed(pr2_r[0])) + 66'($signed(pr2_r[1]))
              + 66'($signed(pr2_r[2]));
      e3_r  <= e2_r;
      nz3_r <= nz2_r;
      g3_r  <= g2_r;

      t4_r  <= 36'(cold_pkg::unit_scale(68'(acc3_r)));
      e4_r  <= e3_r;
      nz4_r <= nz3_r;
      g4_r  <= g3_r;

      for (int j = 0; j < 3; j++) begin
        te5_r[j] <= 67'(t4_r * $signed(e4_r[j]));
      end
      e5_r  <= e4_r;
      nz5_r <= nz4_r;
      g5_r  <= g4_r;

      for (int j = 0; j < 3; j++) begin
        pf6_r[j] <= 36'($signed(g5_r.p[j]))
                  + 36'(cold_pkg::unit_scale(68'($signed(te5_r[j]))));
      end
      e6_r  <= e5_r;
      nz6_r <= nz5_r;
      g6_r  <= g5_r;

      m7_r <= m7_nxt;

      m8_r <= m7_r;
      for (int j = 0; j < 3; j++) begin
        mag8_r[j] <= m7_r.w[j][35] ? (~m7_r.w[j] + 36'd1) : m7_r.w[j];
      end

      m9_r <= m9_nxt;
      for (int j = 0; j < 3; j++) begin
        sq9_r[j] <= mag8_r[j][30:0] * mag8_r[j][30:0];
      end
      d2_9_r <= m8_r.d * m8_r.d;

      m10_r    <= m10_nxt;
      diff10_r <= d2_9_r - w2[61:0];
    end
  end

  cold_isqrt #(
    .PW ($bits(cold_pkg::mid_t))
  ) u_chord (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v10_r),
    .in_x      (diff10_r),
    .in_pl     (m10_r),
    .out_valid (v_sq),
    .out_root  (q_sq),
    .out_pl    (m_sq_raw)
  );

  assign m_sq = cold_pkg::mid_t'(m_sq_raw);

  always_comb begin
    tl_in.e   = m_sq.e;
    tl_in.nz  = m_sq.nz;
    tl_in.far = m_sq.far;
    tl_in.pf  = m_sq.pf;
    tl_in.f   = m_sq.f;
    tl_in.d   = m_sq.d;
    tl_in.q   = q_sq;
  end

  cold_unit #(
    .PW ($bits(cold_pkg::tail_t))
  ) u_off_unit (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v_sq),
    .in_c      (m_sq.w),
    .in_pl     (tl_in),
    .out_valid (v_u2),
    .out_u     (u2),
    .out_nz    (nz_u2),
    .out_pl    (tl_raw)
  );

  assign tl = cold_pkg::tail_t'(tl_raw);

  // A zero offset only occurs when the focus lies on the line, where it is unused.
  always_comb begin
    tl11_nxt = tl;
    if (!nz_u2) begin
      tl11_nxt.far = 1'b0;
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (!tl11_r.nz) begin
        cam12_nxt[j] = 40'($signed(tl11_r.f[j]));
      end else if (tl11_r.far) begin
        cam12_nxt[j] = 40'($signed(tl11_r.f[j]))
                     + cold_pkg::unit_scale(68'($signed(ud11_r[j])));
      end else begin
        cam12_nxt[j] = 40'($signed(tl11_r.pf[j]))
                     - cold_pkg::unit_scale(68'($signed(qe11_r[j])));
      end
    end
    if (!tl11_r.nz) begin
      oc12_nxt = cold_pkg::OUT_ZERO_DIR;
    end else if (tl11_r.far) begin
      oc12_nxt = cold_pkg::OUT_FAR;
    end else begin
      oc12_nxt = cold_pkg::OUT_ON_LINE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v11_r       <= 1'b0;
      v12_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v11_r       <= v_u2;
      v12_r       <= v11_r;
      out_valid_r <= v12_r;
    end
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        qe11_r[j] <= 64'($signed({1'b0, tl.q}) * $signed(tl.e[j]));
        ud11_r[j] <= 63'($signed(u2[j]) * $signed({1'b0, tl.d}));
      end
      tl11_r <= tl11_nxt;

      cam12_r <= cam12_nxt;
      oc12_r  <= oc12_nxt;

      for (int j = 0; j < 3; j++) begin
        cam_out_r[j] <= cold_pkg::sat32($signed(cam12_r[j]));
      end
      oc_out_r <= oc12_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_cam_x   = cam_out_r[0];
  assign out_cam_y   = cam_out_r[1];
  assign out_cam_z   = cam_out_r[2];
  assign out_outcome = oc_out_r;

endmodule

/* test/camera_on_line_at_distance_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_on_line_at_distance_tb
// Drives lines, focus points and distances into the camera placement block
// and checks every result word against a bit-exact predictor built in.
// ----------------------------------------------------------------------------
module camera_on_line_at_distance_tb;

  localparam int LATENCY = 184;

  typedef struct {
    logic [31:0]        x, y, z;
    cold_pkg::outcome_t oc;
  } cam_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_line_px, in_line_py, in_line_pz;
  logic [31:0] in_dir_x, in_dir_y, in_dir_z;
  logic [31:0] in_focus_x, in_focus_y, in_focus_z;
  logic [30:0] in_cam_distance;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_cam_x, out_cam_y, out_cam_z;
  logic [1:0]  out_outcome;

  cam_word_t   expected_cams[$];
  int          mismatches;
  int          words_sent;
  int          words_checked;
  int          outcome_seen[3];
  int          stall_mode;
  bit          stalls_on;

  camera_on_line_at_distance dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("CHECK FAILED");
    $finish;
  end

  // ---- predictor -----------------------------------------------------------

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    mag = v[63] ? -v : v;
  endfunction

  function automatic logic signed [63:0] round_unit(input logic signed [63:0] v);
    logic [63:0] m;
    m = (mag(v) + (64'd1 << (cold_pkg::UNIT_BITS - 1))) >> cold_pkg::UNIT_BITS;
    round_unit = v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [63:0] root_nearest(input logic [63:0] x);
    logic [63:0] r, b, n;
    r = 0;
    b = 64'd1 << 62;
    n = x;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (x - r * r > r) r = r + 1;
    root_nearest = r;
  endfunction

  // Normalises c to UNIT_BITS fraction bits; returns 0 for a zero vector.
  function automatic bit normalise(input logic signed [63:0] c[3],
                                   output logic signed [63:0] u[3]);
    logic [63:0] m[3];
    logic [63:0] big, n2, len, qv;
    big = 0;
    n2 = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag(c[i]);
      if (m[i] > big) big = m[i];
      u[i] = 0;
    end
    if (big == 0) return 1'b0;
    while (big >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      big = big >> 1;
    end
    while (big < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      big = big << 1;
    end
    for (int i = 0; i < 3; i++) n2 = n2 + m[i] * m[i];
    len = root_nearest(n2);
    for (int i = 0; i < 3; i++) begin
      qv = ((m[i] << cold_pkg::UNIT_BITS) + (len >> 1)) / len;
      u[i] = c[i][63] ? -$signed(qv) : $signed(qv);
    end
    return 1'b1;
  endfunction

  function automatic logic [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic cam_word_t place_camera(input logic [31:0] pv[3],
      input logic [31:0] dvv[3], input logic [31:0] fv[3], input logic [30:0] span);
    logic signed [63:0] p[3], dv[3], f[3], e[3], pf[3], w[3], cam[3], u[3];
    logic signed [63:0] acc, t, q;
    logic [63:0] d, w2, d2;
    bit far;
    cam_word_t r;
    acc = 0;
    far = 0;
    d = {33'd0, span};
    for (int i = 0; i < 3; i++) begin
      p[i] = $signed(pv[i]);
      dv[i] = $signed(dvv[i]);
      f[i] = $signed(fv[i]);
    end
    if (!normalise(dv, e)) begin
      for (int i = 0; i < 3; i++) cam[i] = f[i];
      r.oc = cold_pkg::OUT_ZERO_DIR;
    end else begin
      for (int i = 0; i < 3; i++) acc = acc + (f[i] - p[i]) * e[i];
      t = round_unit(acc);
      for (int i = 0; i < 3; i++) begin
        pf[i] = p[i] + round_unit(t * e[i]);
        w[i] = f[i] - pf[i];
        if (mag(w[i]) >= (64'd1 << 31)) far = 1;
      end
      if (!far) begin
        w2 = 0;
        d2 = d * d;
        for (int i = 0; i < 3; i++) w2 = w2 + mag(w[i]) * mag(w[i]);
        if (w2 > d2) begin
          far = 1;
        end else begin
          q = $signed(root_nearest(d2 - w2));
          for (int i = 0; i < 3; i++) cam[i] = pf[i] - round_unit(q * e[i]);
        end
      end
      if (far) begin
        void'(normalise(w, u));
        for (int i = 0; i < 3; i++)
          cam[i] = f[i] + round_unit(u[i] * $signed(d));
        r.oc = cold_pkg::OUT_FAR;
      end else begin
        r.oc = cold_pkg::OUT_ON_LINE;
      end
    end
    r.x = clamp32(cam[0]);
    r.y = clamp32(cam[1]);
    r.z = clamp32(cam[2]);
    return r;
  endfunction

  // ---- driving and checking ------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic send_query(input logic [31:0] pv[3], input logic [31:0] dvv[3],
                            input logic [31:0] fv[3], input logic [30:0] span);
    in_valid <= 1'b1;
    {in_line_px, in_line_py, in_line_pz} <= {pv[0], pv[1], pv[2]};
    {in_dir_x, in_dir_y, in_dir_z} <= {dvv[0], dvv[1], dvv[2]};
    {in_focus_x, in_focus_y, in_focus_z} <= {fv[0], fv[1], fv[2]};
    in_cam_distance <= span;
    do @(posedge clk); while (in_stall);
    expected_cams.insert(expected_cams.size(), place_camera(pv, dvv, fv, span));
    words_sent++;
    @(negedge clk);
  endtask

  task automatic idle_gap(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  always @(posedge clk) begin
    cam_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_cams.size() == 0) begin
        report_mismatch("unexpected word", out_cam_x, 32'd0);
      end else begin
        want = expected_cams.pop_front();
        words_checked++;
        if (out_outcome < 3) outcome_seen[out_outcome]++;
        if (out_cam_x !== want.x) report_mismatch("cam_x", out_cam_x, want.x);
        if (out_cam_y !== want.y) report_mismatch("cam_y", out_cam_y, want.y);
        if (out_cam_z !== want.z) report_mismatch("cam_z", out_cam_z, want.z);
        if (out_outcome !== want.oc) report_mismatch("outcome", out_outcome, want.oc);
      end
    end
  end

  // Receiver stall pattern: phases of none, light, heavy and periodic stalling.
  always @(negedge clk) begin
    if (!stalls_on) begin
      out_stall  <= 1'b0;
      stall_mode <= 1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 7) == 0);
        2: out_stall <= ($urandom_range(0, 2) != 0);
        default: out_stall <= ((($time / 10) % 5) == 0);
      endcase
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    end
  end

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_cams.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord(input int kind);
    case (kind)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      2: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
      default: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 :
                      ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'd0);
    endcase
  endfunction

  // ---- tests ---------------------------------------------------------------

  task automatic test_directed();
    logic [31:0] p[3], dv[3], f[3];
    // Zero direction returns the focus itself.
    p = '{0, 0, 0}; dv = '{0, 0, 0}; f = '{32'h0001_0000, 32'hFFFF_0000, 5};
    send_query(p, dv, f, 31'h7FFF_FFFF);
    // Line through the focus: on the line, d behind it.
    dv = '{32'h0001_0000, 0, 0}; f = '{0, 0, 0};
    send_query(p, dv, f, 31'h000A_0000);
    // Tangent: focus 3 units off, distance exactly 3.
    f = '{32'h0002_0000, 32'h0003_0000, 0};
    send_query(p, dv, f, 31'h0003_0000);
    // Too far: fallback point.
    send_query(p, dv, f, 31'h0001_0000);
    // Zero distance on the line.
    send_query(p, dv, '{32'h0005_0000, 0, 0}, 31'd0);
    // Far line: offset beyond 2^31.
    p = '{32'h8000_0000, 0, 0}; dv = '{0, 32'h0001_0000, 0};
    f = '{32'h7FFF_FFFF, 0, 0};
    send_query(p, dv, f, 31'h7FFF_FFFF);
    // Extremes to exercise saturation.
    p = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    dv = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    f = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    send_query(p, dv, f, 31'h7FFF_FFFF);
    dv = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    send_query(p, dv, f, 31'h7FFF_FFFF);
    send_query(f, dv, p, 31'h7FFF_FFFF);
    dv = '{1, 0, 32'hFFFF_FFFF};
    send_query(p, dv, p, 31'h4000_0000);
    send_query('{0, 0, 0}, '{0, 0, 1}, '{32'h7FFF_FFFF, 32'h8000_0000, 0},
               31'h7FFF_FFFF);
    dv = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    send_query('{32'h1234_5678, 32'hEDCB_A987, 32'h0F0F_0F0F}, dv,
               '{32'h7000_0000, 32'h9000_0000, 32'h0000_0001}, 31'h5555_5555);
    wait_drained();
  endtask

  task automatic test_random(input int count);
    logic [31:0] p[3], dv[3], f[3];
    logic [30:0] span;
    int burst, kind;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 12));
      end
      burst--;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 3; i++) begin
        p[i] = rand_coord(kind < 3 ? 0 : (kind < 9 ? 1 : 3));
        dv[i] = rand_coord(kind == 0 ? 0 : (kind < 9 ? 2 : 3));
        f[i] = rand_coord(kind < 3 ? 0 : (kind < 9 ? 1 : 3));
      end
      if ($urandom_range(0, 49) == 0) dv = '{0, 0, 0};
      if ($urandom_range(0, 7) == 0) dv[$urandom_range(0, 2)] = 0;
      span = (kind == 0 || $urandom_range(0, 9) == 0) ? 31'($urandom) :
             31'($urandom_range(0, 31'h01FF_FFFF));
      send_query(p, dv, f, span);
      // Hold off once mid-run until the pipeline is empty.
      if (n == count / 2) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    stalls_on = 1'b0;
    {in_line_px, in_line_py, in_line_pz} = '0;
    {in_dir_x, in_dir_y, in_dir_z} = '0;
    {in_focus_x, in_focus_y, in_focus_z} = '0;
    in_cam_distance = '0;
    mismatches = 0;
    words_sent = 0;
    words_checked = 0;
    outcome_seen = '{0, 0, 0};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    stalls_on <= 1'b1;
    test_random(1940);
    repeat (LATENCY + 20) @(negedge clk);
    $display("Sent %0d queries, checked %0d camera positions.", words_sent, words_checked);
    $display("Outcomes: on line %0d, fallback %0d, zero direction %0d.",
             outcome_seen[0], outcome_seen[1], outcome_seen[2]);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
